// ===== hw/rtl/output_rate_limiter_latest_wins_defines.svh =====
// ----------------------------------------------------------------------------
// output rate limiter assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef OUTPUT_RATE_LIMITER_LATEST_WINS_DEFINES_SVH
`define OUTPUT_RATE_LIMITER_LATEST_WINS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ORL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rate limiter port check failed");

// next-cycle implication, disabled during reset
`define ORL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rate limiter port check failed");

`endif

// ===== hw/rtl/orl_pkg.sv =====
// ----------------------------------------------------------------------------
// orl_pkg
// types and constants of the output rate limiter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package orl_pkg;

  localparam logic       OP_SEND         = 1'b0;
  localparam logic       OP_TICK         = 1'b1;

  localparam logic [15:0] GAP_RESET      = 16'd150;
  localparam logic [7:0]  LED_MASK       = 8'h1E;
  localparam logic [7:0]  ALL_OFF_FLAG   = 8'h20;
  localparam logic [7:0]  RUMBLE_DURATION = 8'hFE;

  localparam int          PADDR_W        = 3;
  localparam logic [PADDR_W-1:0] REG_MIN_GAP = 3'd0;

  typedef struct packed {
    logic        opcode;
    logic [31:0] now_ms;
    logic [7:0]  led_bits;
    logic [7:0]  left_force;
    logic [7:0]  right_force;
    logic        link_accepts;
  } orl_in_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] out_led_bitmap;
    logic [7:0] out_right_duration;
    logic [7:0] out_right_force;
    logic [7:0] out_left_duration;
    logic [7:0] out_left_force;
    logic       pending_after;
  } orl_out_t;

endpackage

// ===== hw/rtl/output_rate_limiter_latest_wins.sv =====
// ----------------------------------------------------------------------------
// output_rate_limiter_latest_wins
// throttles led and rumble output packets, one latest-wins pending slot
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload      direction
//  in        in_valid / in_ready        orl_in_t     request or tick in
//  out       out_valid / out_ready      orl_out_t    one result per request
//  cfg       psel/penable/pwrite/pready paddr/pwdata min_gap_ms register
//
//  one request per cycle while the out channel is not stalled; each result
//  appears in the output register in the cycle after its request is taken
//  the output register is the only stage: a new request is taken whenever
//  the register is empty or its result leaves in the same cycle
//  a stalled out channel holds the result and stops intake until taken
//  rst (synchronous) clears the slot, the last send time and the output
//  valid, and loads min_gap_ms with 150
//
`timescale 1ns / 1ps

module output_rate_limiter_latest_wins (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  orl_pkg::orl_in_t               in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output orl_pkg::orl_out_t              out_data,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [orl_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  // configuration register
  logic [15:0] min_gap_ms;

  // limiter state
  logic [31:0] last_send_time;
  logic        slot_full;
  logic [7:0]  slot_leds;
  logic [7:0]  slot_left_force;
  logic [7:0]  slot_right_force;

  // per-request decode
  logic        accept;
  logic [31:0] elapsed;
  logic        gap_clear;
  logic        fire;
  logic        slot_full_next;
  logic [7:0]  pkt_leds;
  logic [7:0]  pkt_left;
  logic [7:0]  pkt_right;
  orl_pkg::orl_out_t result_next;

  // apb: always ready, write in the access phase
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap_ms <= orl_pkg::GAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == orl_pkg::REG_MIN_GAP)) begin
      min_gap_ms <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr == orl_pkg::REG_MIN_GAP) begin
      prdata = {16'd0, min_gap_ms};
    end
  end

  // output register empties or drains this cycle
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // wrapping difference; zero last time means nothing sent yet
  assign elapsed   = in_data.now_ms - last_send_time;
  assign gap_clear = (last_send_time == 32'd0) || (elapsed >= {16'd0, min_gap_ms});

  // a tick only fires with something in the slot
  assign fire = gap_clear && in_data.link_accepts &&
                ((in_data.opcode == orl_pkg::OP_SEND) || slot_full);

  // packet source: fresh request or the slot contents
  always_comb begin
    if (in_data.opcode == orl_pkg::OP_SEND) begin
      pkt_leds  = in_data.led_bits;
      pkt_left  = in_data.left_force;
      pkt_right = in_data.right_force;
    end else begin
      pkt_leds  = slot_leds;
      pkt_left  = slot_left_force;
      pkt_right = slot_right_force;
    end
  end

  // slot occupancy after this request
  always_comb begin
    slot_full_next = slot_full;
    if (in_data.opcode == orl_pkg::OP_SEND) begin
      if (!fire) begin
        slot_full_next = 1'b1;   // refused or too soon: newest request wins
      end
    end else if (fire) begin
      slot_full_next = 1'b0;     // drained by tick
    end
  end

  // result; packet fields stay zero when nothing goes out
  always_comb begin
    result_next = '0;
    if (fire) begin
      result_next.send_valid     = 1'b1;
      result_next.out_led_bitmap = ((pkt_leds & orl_pkg::LED_MASK) == 8'd0) ?
                                   (pkt_leds | orl_pkg::ALL_OFF_FLAG) : pkt_leds;
      result_next.out_right_duration = (pkt_right != 8'd0) ? orl_pkg::RUMBLE_DURATION : 8'd0;
      result_next.out_right_force    = pkt_right;
      result_next.out_left_duration  = (pkt_left != 8'd0) ? orl_pkg::RUMBLE_DURATION : 8'd0;
      result_next.out_left_force     = pkt_left;
    end
    result_next.pending_after = slot_full_next;
  end

  // state update on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      last_send_time   <= 32'd0;
      slot_full        <= 1'b0;
      slot_leds        <= 8'd0;
      slot_left_force  <= 8'd0;
      slot_right_force <= 8'd0;
    end else if (accept) begin
      slot_full <= slot_full_next;
      if (fire) begin
        last_send_time <= in_data.now_ms;
      end
      if ((in_data.opcode == orl_pkg::OP_SEND) && !fire) begin
        slot_leds        <= in_data.led_bits;
        slot_left_force  <= in_data.left_force;
        slot_right_force <= in_data.right_force;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result_next;
    end
  end

endmodule

// ===== hw/rtl/orl_checker.sv =====
// ----------------------------------------------------------------------------
// orl_checker
// port-level checks of the output rate limiter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "output_rate_limiter_latest_wins_defines.svh"

module orl_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input orl_pkg::orl_out_t out_data
);

  // stalled result holds
  `ORL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // empty output stage always takes a request
  `ORL_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)

  // no packet means zero packet fields
  `ORL_ASSERT_IMP(a_idle_zero, out_valid && !out_data.send_valid, (out_data.out_led_bitmap == 8'd0) && (out_data.out_right_duration == 8'd0) && (out_data.out_right_force == 8'd0) && (out_data.out_left_duration == 8'd0) && (out_data.out_left_force == 8'd0))

  // all-off flag set when leds 1 to 4 clear
  `ORL_ASSERT_IMP(a_all_off, out_valid && out_data.send_valid && ((out_data.out_led_bitmap & orl_pkg::LED_MASK) == 8'd0), out_data.out_led_bitmap[5])

  // duration follows force
  `ORL_ASSERT_IMP(a_duration, out_valid && out_data.send_valid, (out_data.out_right_duration == ((out_data.out_right_force != 8'd0) ? orl_pkg::RUMBLE_DURATION : 8'd0)) && (out_data.out_left_duration == ((out_data.out_left_force != 8'd0) ? orl_pkg::RUMBLE_DURATION : 8'd0)))

endmodule

bind output_rate_limiter_latest_wins orl_checker u_orl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
